/* design/bdlp_pkg.sv */
// ----------------------------------------------------------------------------
// bdlp_pkg: shared definitions for the button debounce / long press block
// Button count, field widths, register indexes and reset values, and the
// structs passed between the top level, the lanes and the merge stage.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

	// number of debounced buttons, one lane each
	localparam int BUTTON_COUNT = 4;

	// widths of the payload fields
	localparam int FIELD_W  = 4;
	localparam int SETTLE_W = 8;
	localparam int HOLD_W   = 16;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS   = 2'd1;

	localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd30;
	localparam logic [HOLD_W-1:0]   HOLD_RESET   = 16'd800;

	// effective thresholds, zero already mapped to one
	typedef struct packed {
		logic [SETTLE_W-1:0] need_settle;
		logic [HOLD_W-1:0]   need_hold;
	} bdlp_cfg_t;

	// events one lane found on the current tick
	typedef struct packed {
		logic short_ev;
		logic long_ev;
	} bdlp_evt_t;

endpackage

`default_nettype wire

/* design/bdlp_lane.sv */
// ----------------------------------------------------------------------------
// bdlp_lane: debounce and long press core for one button
// Settle counter confirms the raw level; hold counter times a confirmed
// press. State advances once per accepted tick.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_lane
	import bdlp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      advance,
	input  wire logic      raw,
	input  wire bdlp_cfg_t cfg,
	output bdlp_evt_t      evt
);

	logic                last_raw_q;
	logic [SETTLE_W-1:0] settle_count_q;
	logic                settle_pending_q;
	logic                confirmed_q;
	logic [HOLD_W-1:0]   hold_count_q;
	logic                hold_running_q;
	logic                long_done_q;

	logic                last_raw_d;
	logic [SETTLE_W-1:0] settle_count_d;
	logic                settle_pending_d;
	logic                confirmed_d;
	logic [HOLD_W-1:0]   hold_count_d;
	logic                hold_running_d;
	logic                long_done_d;
	logic                short_ev;
	logic                long_ev;
	logic [HOLD_W:0]     hold_next;
	logic [SETTLE_W:0]   settle_next;

	// next state: hold counter first, then settling
	always_comb begin
		last_raw_d       = last_raw_q;
		settle_count_d   = settle_count_q;
		settle_pending_d = settle_pending_q;
		confirmed_d      = confirmed_q;
		hold_count_d     = hold_count_q;
		hold_running_d   = hold_running_q;
		long_done_d      = long_done_q;
		short_ev         = 1'b0;
		long_ev          = 1'b0;
		hold_next        = {1'b0, hold_count_q} + {{HOLD_W{1'b0}}, 1'b1};
		settle_next      = {1'b0, settle_count_q} + {{SETTLE_W{1'b0}}, 1'b1};

		// hold timer, saturates at the threshold
		if (hold_running_q) begin
			if (hold_next >= {1'b0, cfg.need_hold}) begin
				hold_running_d = 1'b0;
				long_done_d    = 1'b1;
				long_ev        = 1'b1;
				hold_count_d   = cfg.need_hold;
			end else begin
				hold_count_d = hold_next[HOLD_W-1:0];
			end
		end

		// settle timer
		if (raw != last_raw_q) begin
			last_raw_d       = raw;
			settle_count_d   = '0;
			settle_pending_d = 1'b1;
		end else if (settle_pending_q) begin
			if (settle_next >= {1'b0, cfg.need_settle}) begin
				settle_pending_d = 1'b0;
				settle_count_d   = cfg.need_settle;
				// settled level differs from confirmed: a real edge
				if (raw != confirmed_q) begin
					confirmed_d = raw;
					if (raw) begin
						long_done_d    = 1'b0;
						hold_count_d   = '0;
						hold_running_d = 1'b1;
					end else begin
						hold_running_d = 1'b0;
						short_ev       = ~long_done_d;
					end
				end
			end else begin
				settle_count_d = settle_next[SETTLE_W-1:0];
			end
		end
	end

	assign evt.short_ev = short_ev;
	assign evt.long_ev  = long_ev;

	// lane state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q       <= 1'b0;
			settle_count_q   <= '0;
			settle_pending_q <= 1'b0;
			confirmed_q      <= 1'b0;
			hold_count_q     <= '0;
			hold_running_q   <= 1'b0;
			long_done_q      <= 1'b0;
		end else if (advance) begin
			last_raw_q       <= last_raw_d;
			settle_count_q   <= settle_count_d;
			settle_pending_q <= settle_pending_d;
			confirmed_q      <= confirmed_d;
			hold_count_q     <= hold_count_d;
			hold_running_q   <= hold_running_d;
			long_done_q      <= long_done_d;
		end
	end

endmodule

`default_nettype wire

/* design/bdlp_merge.sv */
// ----------------------------------------------------------------------------
// bdlp_merge: combines lane events into the result masks
// Packs the per-button events into the output fields and holds them in the
// output register until the receiver takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_merge
	import bdlp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      load,
	input  wire bdlp_evt_t lane_evt [BUTTON_COUNT],
	input  wire logic      out_ready,
	output logic           out_valid,
	output logic [FIELD_W-1:0] short_mask,
	output logic [FIELD_W-1:0] long_mask,
	output logic           free
);

	logic [FIELD_W-1:0] short_bits;
	logic [FIELD_W-1:0] long_bits;
	logic               out_valid_q;
	logic [FIELD_W-1:0] short_mask_q;
	logic [FIELD_W-1:0] long_mask_q;

	// buttons beyond the field width are dropped, missing ones read zero
	for (genvar i = 0; i < FIELD_W; i++) begin : g_bit
		if (i < BUTTON_COUNT) begin : g_lane
			assign short_bits[i] = lane_evt[i].short_ev;
			assign long_bits[i]  = lane_evt[i].long_ev;
		end else begin : g_none
			assign short_bits[i] = 1'b0;
			assign long_bits[i]  = 1'b0;
		end
	end

	// output register is free when empty or drained this cycle
	assign free = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (free) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			short_mask_q <= short_bits;
			long_mask_q  <= long_bits;
		end
	end

	assign out_valid  = out_valid_q;
	assign short_mask = short_mask_q;
	assign long_mask  = long_mask_q;

endmodule

`default_nettype wire

/* design/button_debounce_long_press_top.sv */
// ----------------------------------------------------------------------------
// button_debounce_long_press_top: debounce and long press for push buttons
// Each input transfer is one time tick with the raw level of every button;
// each produces one result transfer with short and long press masks.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid/in_ready, raw_levels (bit b = button b pressed).
//   out channel : out_valid/out_ready, short_mask and long_mask for that tick.
//   cfg channel : cfg_valid/cfg_ready/cfg_index/cfg_data, always ready;
//                 index 0 = settle_ticks (8 bit), 1 = hold_ticks (16 bit),
//                 other indexes are ignored. Zero thresholds act as one.
// Output: the masks of a tick are registered and appear in the cycle after its transfer.
// Throughput: one tick per cycle while the output register is free; one lane
//   per button updates its settle and hold counters in the accepting cycle,
//   and the merge stage registers the masks.
// Stall: the output register holds a result until taken; a new tick is
//   accepted in the same cycle the held result leaves. in_ready drops only
//   while a result waits and out_ready is low.
// Reset: all buttons released and idle, no result pending, settle_ticks 30,
//   hold_ticks 800.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_long_press_top
	import bdlp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [FIELD_W-1:0]     raw_levels,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [FIELD_W-1:0]          short_mask,
	output logic [FIELD_W-1:0]          long_mask,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [SETTLE_W-1:0] settle_ticks_q;
	logic [HOLD_W-1:0]   hold_ticks_q;
	bdlp_cfg_t           cfg;
	bdlp_evt_t           lane_evt [BUTTON_COUNT];
	logic                free;
	logic                advance;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_ticks_q <= SETTLE_RESET;
			hold_ticks_q   <= HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SETTLE_TICKS: settle_ticks_q <= cfg_data[SETTLE_W-1:0];
				REG_HOLD_TICKS:   hold_ticks_q   <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// zero thresholds behave like one
	assign cfg.need_settle = (settle_ticks_q == '0) ? SETTLE_W'(1) : settle_ticks_q;
	assign cfg.need_hold   = (hold_ticks_q == '0) ? HOLD_W'(1) : hold_ticks_q;

	// input transfer
	assign in_ready = free;
	assign advance  = in_valid & free;

	// one lane per button
	for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_lane
		logic raw_bit;
		if (b < FIELD_W) begin : g_in
			assign raw_bit = raw_levels[b];
		end else begin : g_zero
			assign raw_bit = 1'b0;
		end

		bdlp_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.raw     (raw_bit),
			.cfg     (cfg),
			.evt     (lane_evt[b])
		);
	end

	// merge and output register
	bdlp_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.lane_evt   (lane_evt),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.short_mask (short_mask),
		.long_mask  (long_mask),
		.free       (free)
	);

endmodule

`default_nettype wire

/* design/bdlp_checker.sv */
// ----------------------------------------------------------------------------
// bdlp_checker: port-level checks for the debounce / long press block
// Watches the top level's channels; bound to every instance of the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_checker
	import bdlp_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [FIELD_W-1:0]     short_mask,
	input wire logic [FIELD_W-1:0]     long_mask
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(short_mask) && $stable(long_mask))
		else $error("result changed while stalled");

	// every accepted tick yields a result in the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted tick produced no result");

	// an empty output register never back-pressures the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// a long press on a tick suppresses the short press of the same button
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (short_mask & long_mask) == '0)
		else $error("short and long press on the same button");

endmodule

bind button_debounce_long_press_top bdlp_checker u_bdlp_checker (.*);

`default_nettype wire

/* dv/button_debounce_long_press_top_test.sv */
// ----------------------------------------------------------------------------
// button_debounce_long_press_top_test: self-checking bench for the debouncer
// Drives raw button levels one tick per transfer. A scoreboard class keeps its
// own per-button debounce and hold state and predicts the short and long press
// masks of every tick. Each result is checked in order. Runs a directed set of
// corner cases, then random press/release/bounce patterns under several
// threshold settings, with random and long stalls on both channels.
// ----------------------------------------------------------------------------
module button_debounce_long_press_top_test;
	import bdlp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int STALL_CYCLES   = 60;
	localparam int PRINT_LIMIT    = 20;

	// unused register slot, writes there must be ignored
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [FIELD_W-1:0] short_m;
		logic [FIELD_W-1:0] long_m;
	} press_masks_t;

	// predicts press masks per tick and checks the results in order
	class press_event_board;
		bit [SETTLE_W-1:0]     settle_ticks;
		bit [HOLD_W-1:0]       hold_ticks;
		bit [BUTTON_COUNT-1:0] last_raw;
		bit [BUTTON_COUNT-1:0] settle_pending;
		bit [BUTTON_COUNT-1:0] confirmed;
		bit [BUTTON_COUNT-1:0] hold_running;
		bit [BUTTON_COUNT-1:0] long_done;
		bit [SETTLE_W-1:0]     settle_cnt [BUTTON_COUNT];
		bit [HOLD_W-1:0]       hold_cnt [BUTTON_COUNT];
		press_masks_t          expected_masks [$];
		int ticks;
		int results;
		int shorts_seen;
		int longs_seen;
		int mismatches;

		function new();
			settle_ticks = SETTLE_RESET;
			hold_ticks   = HOLD_RESET;
		endfunction

		function void write_register(logic [CFG_INDEX_W-1:0] idx,
				logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SETTLE_TICKS: settle_ticks = data[SETTLE_W-1:0];
				REG_HOLD_TICKS:   hold_ticks = data[HOLD_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_masks.size();
		endfunction

		function void report(string msg);
			if (mismatches < PRINT_LIMIT)
				$display("ERROR at result %0d: %s", results, msg);
			mismatches++;
		endfunction

		// one accepted tick: hold counters first, then settling
		function void take_tick(logic [FIELD_W-1:0] raw);
			press_masks_t      m;
			logic [SETTLE_W:0] need_s;
			logic [SETTLE_W:0] s;
			logic [HOLD_W:0]   need_h;
			logic [HOLD_W:0]   h;
			logic              lvl;
			m = '0;
			need_s = (settle_ticks == '0) ? (SETTLE_W+1)'(1) : {1'b0, settle_ticks};
			need_h = (hold_ticks == '0) ? (HOLD_W+1)'(1) : {1'b0, hold_ticks};
			for (int b = 0; b < BUTTON_COUNT; b++) begin
				lvl = (b < FIELD_W) ? raw[b] : 1'b0;
				// hold counter, may fire a long press
				if (hold_running[b]) begin
					h = {1'b0, hold_cnt[b]} + (HOLD_W+1)'(1);
					if (h >= need_h) begin
						hold_running[b] = 1'b0;
						long_done[b] = 1'b1;
						m.long_m[b] = 1'b1;
						h = need_h;
					end
					hold_cnt[b] = h[HOLD_W-1:0];
				end
				// settle the raw level
				if (lvl != last_raw[b]) begin
					last_raw[b] = lvl;
					settle_cnt[b] = '0;
					settle_pending[b] = 1'b1;
				end else if (settle_pending[b]) begin
					s = {1'b0, settle_cnt[b]} + (SETTLE_W+1)'(1);
					if (s >= need_s) begin
						settle_pending[b] = 1'b0;
						s = need_s;
						// a settled level equal to the confirmed one is a glitch
						if (lvl != confirmed[b]) begin
							confirmed[b] = lvl;
							if (lvl) begin
								long_done[b] = 1'b0;
								hold_cnt[b] = '0;
								hold_running[b] = 1'b1;
							end else begin
								hold_running[b] = 1'b0;
								if (!long_done[b])
									m.short_m[b] = 1'b1;
							end
						end
					end
					settle_cnt[b] = s[SETTLE_W-1:0];
				end
			end
			expected_masks.push_back(m);
			ticks++;
		endfunction

		function void check_masks(logic [FIELD_W-1:0] short_got,
				logic [FIELD_W-1:0] long_got);
			press_masks_t want;
			if (expected_masks.size() == 0) begin
				report($sformatf("result with no tick pending (short %h long %h)",
					short_got, long_got));
			end else begin
				want = expected_masks.pop_front();
				if (short_got !== want.short_m)
					report($sformatf("short_mask got %h expected %h",
						short_got, want.short_m));
				if (long_got !== want.long_m)
					report($sformatf("long_mask got %h expected %h",
						long_got, want.long_m));
			end
			shorts_seen += $countones(short_got);
			longs_seen += $countones(long_got);
			results++;
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [FIELD_W-1:0]     raw_levels = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [FIELD_W-1:0]     short_mask;
	logic [FIELD_W-1:0]     long_mask;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	press_event_board board = new();

	int sender_gap_pct = 24;
	int receiver_gap_pct = 62;
	bit stall_request = 1'b0;
	int settings_run = 0;

	// thresholds in effect, used to shape the press patterns
	int cur_settle = 30;
	int cur_hold = 800;
	bit [BUTTON_COUNT-1:0] seg_level = '0;
	int seg_left [BUTTON_COUNT] = '{default: 0};

	button_debounce_long_press_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.raw_levels (raw_levels),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.short_mask (short_mask),
		.long_mask  (long_mask),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// one config transfer; caller lowers cfg_valid after the last one
	task automatic cfg_transfer(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.write_register(idx, data);
	endtask

	// settle data carries junk in the upper byte, the block keeps 8 bits
	task automatic set_thresholds(input int settle_val, input int hold_val);
		logic [7:0] junk;
		junk = 8'($urandom_range(0, 255));
		cfg_transfer(REG_SETTLE_TICKS, {junk, settle_val[7:0]});
		cfg_transfer(REG_HOLD_TICKS, hold_val[15:0]);
		cfg_valid <= 1'b0;
		cur_settle = (settle_val == 0) ? 1 : settle_val;
		cur_hold = (hold_val == 0) ? 1 : hold_val;
	endtask

	task automatic send_tick(input logic [FIELD_W-1:0] value);
		while ($urandom_range(0, 99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		raw_levels <= value;
		do @(posedge clk); while (!in_ready);
		board.take_tick(value);
	endtask

	task automatic wait_drained();
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic end_phase();
		in_valid <= 1'b0;
		wait_drained();
		settings_run++;
	endtask

	// length of the next stable stretch of one button
	function automatic int segment_length();
		int kind;
		int len;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1:    len = $urandom_range(1, cur_settle);
			2, 3, 4: len = $urandom_range(cur_settle + 1, cur_settle + cur_hold);
			// release settles on the tick the long press fires
			5:       len = (cur_hold > cur_settle) ? cur_hold : cur_settle + 1;
			6, 7:    len = cur_hold + $urandom_range(1, 2 * cur_settle + 5);
			default: len = $urandom_range(1, 3 * cur_settle + 3);
		endcase
		if (len > 700)
			len = $urandom_range(200, 700);
		if (len < 1)
			len = 1;
		return len;
	endfunction

	// press, release and bounce patterns per button, with some noise ticks
	task automatic next_levels(output logic [FIELD_W-1:0] value);
		value = '0;
		for (int b = 0; b < BUTTON_COUNT; b++) begin
			if (seg_left[b] == 0) begin
				seg_level[b] = ~seg_level[b];
				seg_left[b] = segment_length();
			end
			if (b < FIELD_W)
				value[b] = seg_level[b];
			seg_left[b]--;
		end
		if ($urandom_range(0, 99) < 6)
			value = FIELD_W'($urandom_range(0, 15));
	endtask

	task automatic run_phase(input int settle_val, input int hold_val,
			input int count, input bit pressure);
		logic [FIELD_W-1:0] value;
		set_thresholds(settle_val, hold_val);
		for (int i = 0; i < count; i++) begin
			// sender pause until the block is empty
			if (pressure && i == count / 4) begin
				in_valid <= 1'b0;
				wait_drained();
			end
			// receiver holds off while ticks keep coming
			if (pressure && i == count / 2)
				stall_request = 1'b1;
			next_levels(value);
			send_tick(value);
		end
		end_phase();
	endtask

	// result side: random backpressure plus requested long stalls
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		forever begin
			if (stall_request) begin
				stall_left = STALL_CYCLES;
				stall_request = 1'b0;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= receiver_gap_pct);
			end
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_masks(short_mask, long_mask);
		end
	end

	// ends the run when no channel moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("button_debounce_long_press_top_test failed");
		$finish;
	end

	initial begin : main
		logic [FIELD_W-1:0] zero_thresh_seq [8];
		logic [FIELD_W-1:0] short_long_seq [12];
		// zero thresholds act as one: press, long, release without short,
		// then a bounce that settles back to released
		zero_thresh_seq = '{4'hF, 4'hF, 4'hF, 4'h0, 4'h0, 4'hA, 4'h0, 4'h0};
		// settle 2, hold 4: long press and release on one tick, then a short
		short_long_seq = '{4'hC, 4'hC, 4'hC, 4'hC, 4'h0, 4'h0,
			4'h3, 4'h3, 4'h3, 4'h0, 4'h0, 4'h0};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed corner cases
		cfg_transfer(REG_SPARE, 16'hFFFF);
		set_thresholds(0, 0);
		foreach (zero_thresh_seq[i])
			send_tick(zero_thresh_seq[i]);
		end_phase();
		set_thresholds(2, 4);
		foreach (short_long_seq[i])
			send_tick(short_long_seq[i]);
		end_phase();

		// random patterns, sender idles less than receiver
		run_phase(3, 20, 300, 1'b1);
		run_phase(SETTLE_RESET, HOLD_RESET, 150, 1'b0);

		// receiver idles less than sender
		sender_gap_pct = 62;
		receiver_gap_pct = 24;
		run_phase(1, 1, 200, 1'b0);
		run_phase($urandom_range(2, 10), $urandom_range(5, 80), 250, 1'b1);

		// no idling at all
		sender_gap_pct = 0;
		receiver_gap_pct = 0;
		run_phase(255, 65535, 300, 1'b0);
		run_phase($urandom_range(1, 6), $urandom_range(1, 30), 300, 1'b0);

		repeat (4) @(posedge clk);
		$display("ran %0d ticks under %0d threshold settings with random stalls",
			board.ticks, settings_run);
		$display("checked %0d results: %0d short and %0d long presses, %0d errors",
			board.results, board.shorts_seen, board.longs_seen, board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("button_debounce_long_press_top_test passed");
		else
			$display("button_debounce_long_press_top_test failed");
		$finish;
	end

endmodule
